// File: hw/rtl/rank_smallest_positive_timers_defines.svh
// assertion helpers, clocked on aclk and held off during reset
`ifndef RANK_SMALLEST_POSITIVE_TIMERS_DEFINES_SVH
`define RANK_SMALLEST_POSITIVE_TIMERS_DEFINES_SVH

// condition that holds at every edge
`define RSPT_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("rspt check failed");

// consequence in the same cycle
`define RSPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rspt check failed");

// consequence in the next cycle
`define RSPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rspt check failed");

`endif

// File: hw/rtl/rspt_pkg.sv
package rspt_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int MAX_REPORTED = 5;

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = $clog2(MAX_CHANNELS);
    localparam int RANK_W = $clog2(MAX_REPORTED + 1);

    // field widths of the ports
    localparam int VAL_W     = 19;
    localparam int VALUE_W   = 18;
    localparam int RANK_OUT_W = 3;
    localparam int CH_OUT_W  = 5;
    localparam int HOURS_W   = 7;
    localparam int MINS_W    = 6;
    localparam int SECS_W    = 6;
    localparam int REM_W     = 12;

    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;

    // reciprocal constants: floor(v * M >> K) equals v / D over the value range
    localparam int HOUR_SHIFT  = 30;
    localparam int HOUR_MULT_W = 19;
    localparam logic [HOUR_MULT_W-1:0] HOUR_MULT = HOUR_MULT_W'(298262);
    localparam int MIN_SHIFT   = 20;
    localparam int MIN_MULT_W  = 15;
    localparam logic [MIN_MULT_W-1:0] MIN_MULT = MIN_MULT_W'(17477);

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_EMPTY,
        S_FETCH,
        S_HOURS,
        S_REM,
        S_MINS,
        S_SECS,
        S_SEND
    } state_t;

    typedef struct packed {
        logic load_item;
        logic start_run;
        logic set_empty;
        logic fetch;
        logic calc_hours;
        logic calc_rem;
        logic calc_mins;
        logic calc_secs;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic has_pos;
    } status_t;

endpackage

// File: hw/rtl/rspt_ctrl.sv
module rspt_ctrl
    import rspt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last_item,
    input  logic    m_ready,
    input  logic    m_last_result,
    input  status_t status,
    output logic    s_ready,
    output logic    m_valid,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_valid && s_last_item) state_next = S_START;
            end
            S_START: begin
                state_next = status.has_pos ? S_FETCH : S_EMPTY;
            end
            S_EMPTY: state_next = S_SEND;
            S_FETCH: state_next = S_HOURS;
            S_HOURS: state_next = S_REM;
            S_REM:   state_next = S_MINS;
            S_MINS:  state_next = S_SECS;
            S_SECS:  state_next = S_SEND;
            S_SEND: begin
                if (m_ready) state_next = m_last_result ? S_LOAD : S_FETCH;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            S_LOAD: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            S_START: cmd.start_run  = 1'b1;
            S_EMPTY: cmd.set_empty  = 1'b1;
            S_FETCH: cmd.fetch      = 1'b1;
            S_HOURS: cmd.calc_hours = 1'b1;
            S_REM:   cmd.calc_rem   = 1'b1;
            S_MINS:  cmd.calc_mins  = 1'b1;
            S_SECS:  cmd.calc_secs  = 1'b1;
            S_SEND: begin
                m_valid     = 1'b1;
                cmd.advance = m_ready && !m_last_result;
                cmd.finish  = m_ready && m_last_result;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/rspt_dpath.sv
module rspt_dpath
    import rspt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    input  logic signed [VAL_W-1:0]   in_value,
    output status_t                   status,
    output logic                      entry_valid,
    output logic [RANK_OUT_W-1:0]     rank,
    output logic [CH_OUT_W-1:0]       channel_number,
    output logic [VALUE_W-1:0]        value_seconds,
    output logic [HOURS_W-1:0]        hours_part,
    output logic [MINS_W-1:0]         minutes_part,
    output logic [SECS_W-1:0]         seconds_part,
    output logic                      last_result
);

    // sorted insertion chain, entries at or above count_reg hold stale data
    logic signed [VAL_W-1:0] val_reg  [MAX_CHANNELS];
    logic signed [VAL_W-1:0] val_next [MAX_CHANNELS];
    logic [CNT_W-1:0]        ch_reg   [MAX_CHANNELS];
    logic [CNT_W-1:0]        ch_next  [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] take;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] npos_reg;
    logic             store_en;

    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              entry_valid_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  ch_out_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [HOURS_W-1:0] hours_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [MINS_W-1:0]  mins_reg;
    logic [SECS_W-1:0]  secs_reg;

    logic [VALUE_W+HOUR_MULT_W-1:0] hour_prod;
    logic [REM_W+MIN_MULT_W-1:0]    min_prod;
    logic                           last_entry;

    assign store_en = cmd.load_item && (count_reg < CNT_W'(MAX_CHANNELS));

    // entries after the insertion point shift up by one
    always_comb begin
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            take[i] = ((CNT_W'(i) < count_reg) && (val_reg[i] > in_value))
                      || (CNT_W'(i) == count_reg);
        end
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            val_next[i] = val_reg[i];
            ch_next[i]  = ch_reg[i];
            if (take[i]) begin
                if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
                    val_next[i] = val_reg[(i > 0) ? i - 1 : 0];
                    ch_next[i]  = ch_reg[(i > 0) ? i - 1 : 0];
                end else begin
                    val_next[i] = in_value;
                    ch_next[i]  = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                val_reg[i] <= val_next[i];
                ch_reg[i]  <= ch_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            npos_reg  <= '0;
        end else if (store_en) begin
            count_reg <= count_reg + CNT_W'(1);
            if (in_value <= 0) npos_reg <= npos_reg + CNT_W'(1);
        end else if (cmd.finish) begin
            count_reg <= '0;
            npos_reg  <= '0;
        end
    end

    // positive entries sit at the top of the chain, starting at npos_reg
    assign status.has_pos = (count_reg != npos_reg);
    assign last_entry = (rank_reg == RANK_W'(MAX_REPORTED))
                        || (rd_ptr_reg + CNT_W'(1) == count_reg);

    assign hour_prod = value_reg * HOUR_MULT;
    assign min_prod  = rem_reg * MIN_MULT;

    always_ff @(posedge aclk) begin
        if (cmd.start_run) begin
            rd_ptr_reg <= npos_reg;
            rank_reg   <= RANK_W'(1);
        end else if (cmd.advance) begin
            rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            rank_reg   <= rank_reg + RANK_W'(1);
        end else if (cmd.set_empty) begin
            rank_reg   <= '0;
        end

        if (cmd.set_empty) begin
            entry_valid_reg <= 1'b0;
            last_reg        <= 1'b1;
            ch_out_reg      <= '0;
            value_reg       <= '0;
            hours_reg       <= '0;
            mins_reg        <= '0;
            secs_reg        <= '0;
        end
        if (cmd.fetch) begin
            entry_valid_reg <= 1'b1;
            value_reg  <= val_reg[rd_ptr_reg[IDX_W-1:0]][VALUE_W-1:0];
            ch_out_reg <= ch_reg[rd_ptr_reg[IDX_W-1:0]];
        end
        if (cmd.calc_hours) begin
            hours_reg <= hour_prod[HOUR_SHIFT +: HOURS_W];
        end
        if (cmd.calc_rem) begin
            rem_reg <= REM_W'(value_reg - VALUE_W'(hours_reg * SECS_PER_HOUR));
        end
        if (cmd.calc_mins) begin
            mins_reg <= min_prod[MIN_SHIFT +: MINS_W];
        end
        if (cmd.calc_secs) begin
            secs_reg <= SECS_W'(rem_reg - REM_W'(mins_reg * SECS_PER_MIN));
            last_reg <= last_entry;
        end
    end

    assign entry_valid    = entry_valid_reg;
    assign rank           = RANK_OUT_W'(rank_reg);
    assign channel_number = CH_OUT_W'(ch_out_reg);
    assign value_seconds  = value_reg;
    assign hours_part     = hours_reg;
    assign minutes_part   = mins_reg;
    assign seconds_part   = secs_reg;
    assign last_result    = last_reg;

endmodule

// File: hw/rtl/rank_smallest_positive_timers.sv
// Ranks the smallest positive timers of a load of up to sixteen channels.
// Input channel (s_): one signed remaining-seconds word per channel, channel
// numbers follow arrival order from one. s_last_item closes the load. Words
// past the sixteenth are dropped, but a dropped word with s_last_item still
// closes the load.
// Loading takes one word per cycle: each word is placed into a sorted chain
// of registers in the cycle it is accepted.
// After the last word s_ready stays low while results go out on m_: up to
// five positive entries, smallest first (ties to the lower channel), with
// rank, channel and the value as hours, minutes and seconds. With no
// positive entry one result with m_entry_valid low is sent. m_last_result
// marks the final result, after which the next load may start.
// The first result follows the START, FETCH, HOURS, REM, MINS and SECS states
// after the last word is accepted (START and EMPTY when no entry is positive),
// each further one FETCH through SECS after the previous is taken: the
// hours/minutes split runs through two reciprocal multiplies and two remainder steps in turn.
// A stalled result holds on m_ until m_ready. Reset empties the load and
// returns the block to loading.
module rank_smallest_positive_timers
    import rspt_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_remaining_seconds,
    input  logic                    s_last_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_entry_valid,
    output logic [RANK_OUT_W-1:0]   m_rank,
    output logic [CH_OUT_W-1:0]     m_channel_number,
    output logic [VALUE_W-1:0]      m_value_seconds,
    output logic [HOURS_W-1:0]      m_hours_part,
    output logic [MINS_W-1:0]       m_minutes_part,
    output logic [SECS_W-1:0]       m_seconds_part,
    output logic                    m_last_result
);

`include "rank_smallest_positive_timers_defines.svh"

    cmd_t    cmd;
    status_t status;

    rspt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_last_item   (s_last_item),
        .m_ready       (m_ready),
        .m_last_result (m_last_result),
        .status        (status),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .cmd           (cmd)
    );

    rspt_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .in_value       (s_remaining_seconds),
        .status         (status),
        .entry_valid    (m_entry_valid),
        .rank           (m_rank),
        .channel_number (m_channel_number),
        .value_seconds  (m_value_seconds),
        .hours_part     (m_hours_part),
        .minutes_part   (m_minutes_part),
        .seconds_part   (m_seconds_part),
        .last_result    (m_last_result)
    );

    // loading and result phases never overlap
    `RSPT_ASSERT_ALWAYS(a_phase_excl, !(s_ready && m_valid))
    // a valid entry carries a rank in range and a positive value
    `RSPT_ASSERT_IMPL(a_rank_range, m_valid && m_entry_valid,
        m_rank != 0 && m_rank <= MAX_REPORTED && m_value_seconds != 0)
    // the empty result is always the only one
    `RSPT_ASSERT_IMPL(a_empty_last, m_valid && !m_entry_valid, m_last_result)
    // once the final result is taken a new load opens
    `RSPT_ASSERT_NEXT(a_reopen, m_valid && m_ready && m_last_result, s_ready)

endmodule
